// ----- design/adc_pkg.sv -----
// Package for the alphanumeric display controller: request and response types,
// command and byte codes, and the character, segment and ASCII tables.
// Depends on nothing; every design file uses it by scoped names.
package adc_pkg;

    // Number of digit positions in the display RAM.
    localparam int DIGITS = 16;

    // Commands carried by a request.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_ENABLE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Top three bits of a written byte that select a control function.
    localparam logic [2:0] TOP_TEST   = 3'b100;
    localparam logic [2:0] TOP_CURSOR = 3'b101;
    localparam logic [2:0] TOP_COUNT  = 3'b110;
    localparam logic [2:0] TOP_DUTY   = 3'b111;

    // Characters with a meaning of their own.
    localparam logic [5:0] CH_NULL  = 6'h00;
    localparam logic [5:0] CH_BLANK = 6'h20;
    localparam logic [5:0] CH_COMMA = 6'h2C;
    localparam logic [5:0] CH_DOT   = 6'h2E;

    // Reset values of the control state.
    localparam logic [3:0] CURSOR_RESET = 4'(DIGITS - 1);
    localparam logic [4:0] COUNT_RESET  = 5'(DIGITS);

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic [3:0] digit_index;
    } t_req;

    typedef struct packed {
        logic [15:0] segment_pattern;
        logic [6:0]  ascii_code;
        logic [7:0]  punct_mark;
        logic        display_changed;
        logic        intensity_changed;
        logic [4:0]  intensity_now;
        logic [4:0]  digit_count_now;
        logic [3:0]  cursor_now;
        logic        enabled_now;
    } t_rsp;

    // Stored character to standardized character code.
    localparam logic [5:0] STD_CODE [64] = '{
         0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15,
        16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 32, 28, 32, 32, 31,
        32, 32, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45, 46, 47,
        48, 49, 50, 51, 52, 53, 54, 55, 56, 57, 57, 58, 59, 60, 61, 62
    };

    // Standardized code to sixteen-segment pattern.
    localparam logic [15:0] SEG_TABLE [64] = '{
        20607, 17615, 5439, 243, 4415, 16627, 16579, 1275,
        17612, 4403, 124, 19136, 240, 33484, 35020, 255,
        17607, 2303, 19655, 17595, 4355, 252, 8896, 10444,
        43520, 37376, 8755, 225, 34816, 30, 10240, 48,
        0, 33057, 384, 21820, 4539, 30617, 51577, 512,
        2560, 40960, 65280, 21760, 0, 17408, 0, 8704,
        8959, 4352, 17527, 17471, 17548, 17595, 17659, 15,
        17663, 17599, 33, 8193, 17456, 17456, 786, 5127
    };

    // Standardized code to ASCII code.
    localparam logic [6:0] ASC_TABLE [64] = '{
        7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
        7'h48, 7'h49, 7'h4a, 7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h4f,
        7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h5a, 7'h3c, 7'h2f, 7'h3e, 7'h5e, 7'h5f,
        7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27,
        7'h28, 7'h29, 7'h2a, 7'h2b, 7'h2c, 7'h2d, 7'h2e, 7'h2f,
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h3d, 7'h20, 7'h3d, 7'h20, 7'h21, 7'h3f
    };

endpackage

// ----- design/adc_decode.sv -----
// Character decoder: maps a stored 6-bit character to its segment pattern
// and remapped ASCII code through the package tables. Depends on adc_pkg.
module adc_decode (
    input  logic [5:0]  i_char,
    output logic [15:0] o_segments,
    output logic [6:0]  o_ascii
);

    logic [5:0] code;

    // Standardize the character first, then look both tables up by that code.
    assign code       = adc_pkg::STD_CODE[i_char];
    assign o_segments = adc_pkg::SEG_TABLE[code];
    assign o_ascii    = adc_pkg::ASC_TABLE[code];

endmodule

// ----- design/adc_core.sv -----
// Controller core: digit RAM, cursor, duty, digit count and enable state,
// with the command execution logic that forms one response per request.
// Depends on adc_pkg and adc_decode.
module adc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_exec,
    input  adc_pkg::t_req i_req,
    output adc_pkg::t_rsp o_rsp
);

    localparam int DIGITS = adc_pkg::DIGITS;

    // Digit RAM held in flip-flops: character and punctuation byte per digit.
    logic [5:0] r_char  [DIGITS];
    logic [7:0] r_punct [DIGITS];

    logic [3:0] r_cursor, n_cursor;
    logic [4:0] r_duty,   n_duty;
    logic [4:0] r_count,  n_count;
    logic       r_en,     n_en;

    logic [2:0]  top;
    logic [5:0]  ch;
    logic        is_punct;
    logic [3:0]  addr;
    logic [5:0]  rd_char;
    logic [7:0]  rd_punct;
    logic [15:0] dec_seg;
    logic [6:0]  dec_asc;
    logic        wr_en;
    logic [5:0]  wr_char;
    logic [7:0]  wr_punct;
    logic        clr;
    logic        disp_chg;
    logic        int_chg;
    logic        is_read;

    // Byte fields and the single RAM address this request touches.
    assign top      = i_req.data_byte[7:5];
    assign ch       = i_req.data_byte[5:0];
    assign is_punct = (ch == adc_pkg::CH_DOT) || (ch == adc_pkg::CH_COMMA);
    assign is_read  = (i_req.command == adc_pkg::CMD_READ);

    always_comb begin
        if (is_read) begin
            addr = i_req.digit_index;
        end else if (is_punct) begin
            addr = r_cursor;
        end else begin
            addr = r_cursor + 4'd1;
        end
    end

    assign rd_char  = r_char[addr];
    assign rd_punct = r_punct[addr];

    adc_decode u_decode (
        .i_char     (rd_char),
        .o_segments (dec_seg),
        .o_ascii    (dec_asc)
    );

    // Command execution: next state, RAM write and change flags.
    always_comb begin
        n_cursor = r_cursor;
        n_duty   = r_duty;
        n_count  = r_count;
        n_en     = r_en;
        wr_en    = 1'b0;
        wr_char  = rd_char;
        wr_punct = rd_punct;
        clr      = 1'b0;
        disp_chg = 1'b0;
        int_chg  = 1'b0;
        unique case (i_req.command)
            adc_pkg::CMD_WRITE: begin
                if (r_en) begin
                    unique case (top)
                        adc_pkg::TOP_DUTY: begin
                            n_duty  = i_req.data_byte[4:0];
                            int_chg = (i_req.data_byte[4:0] != r_duty);
                        end
                        adc_pkg::TOP_CURSOR: begin
                            n_cursor = i_req.data_byte[3:0];
                        end
                        adc_pkg::TOP_COUNT: begin
                            n_count = (i_req.data_byte[4:0] == 5'd0) ?
                                      adc_pkg::COUNT_RESET : i_req.data_byte[4:0];
                        end
                        adc_pkg::TOP_TEST: begin
                            // Test mode has no effect.
                        end
                        default: begin
                            if (is_punct) begin
                                wr_en    = 1'b1;
                                wr_punct = rd_punct | {2'b00, ch};
                                disp_chg = (rd_punct == 8'd0);
                            end else if (ch != adc_pkg::CH_NULL) begin
                                n_cursor = addr;
                                wr_en    = 1'b1;
                                wr_char  = ch;
                                wr_punct = 8'd0;
                                disp_chg = (rd_char != ch);
                            end
                        end
                    endcase
                end
            end
            adc_pkg::CMD_READ: begin
                // Reads leave the state alone.
            end
            adc_pkg::CMD_ENABLE: begin
                if (i_req.data_byte[0]) begin
                    n_en = 1'b1;
                end else begin
                    n_en     = 1'b0;
                    clr      = 1'b1;
                    n_cursor = adc_pkg::CURSOR_RESET;
                    n_duty   = 5'd0;
                    n_count  = adc_pkg::COUNT_RESET;
                    disp_chg = 1'b1;
                    int_chg  = 1'b1;
                end
            end
            default: begin
                // Unused command: no effect.
            end
        endcase
    end

    // Response fields: read data only for reads, status after this request.
    always_comb begin
        o_rsp.segment_pattern   = is_read ? dec_seg  : 16'd0;
        o_rsp.ascii_code        = is_read ? dec_asc  : 7'd0;
        o_rsp.punct_mark        = is_read ? rd_punct : 8'd0;
        o_rsp.display_changed   = disp_chg;
        o_rsp.intensity_changed = int_chg;
        o_rsp.intensity_now     = n_duty;
        o_rsp.digit_count_now   = n_count;
        o_rsp.cursor_now        = n_cursor;
        o_rsp.enabled_now       = n_en;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= adc_pkg::CURSOR_RESET;
            r_duty   <= 5'd0;
            r_count  <= adc_pkg::COUNT_RESET;
            r_en     <= 1'b0;
        end else if (i_exec) begin
            r_cursor <= n_cursor;
            r_duty   <= n_duty;
            r_count  <= n_count;
            r_en     <= n_en;
        end
    end

    // Digit RAM: cleared to blanks on reset or disable, else one write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_exec && clr)) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_char[i]  <= adc_pkg::CH_BLANK;
                r_punct[i] <= 8'd0;
            end
        end else if (i_exec && wr_en) begin
            r_char[addr]  <= wr_char;
            r_punct[addr] <= wr_punct;
        end
    end

    // A disable request returns the control state to its reset values.
    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_exec && (i_req.command == adc_pkg::CMD_ENABLE) && !i_req.data_byte[0]
        |=> (r_cursor == adc_pkg::CURSOR_RESET) && (r_duty == 5'd0) &&
            (r_count == adc_pkg::COUNT_RESET) && !r_en)
        else $error("disable did not restore the control state");

    // Writes while disabled change nothing.
    a_disabled_write_inert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_exec && (i_req.command == adc_pkg::CMD_WRITE) && !r_en
        |=> $stable(r_cursor) && $stable(r_duty) && $stable(r_count) && !r_en)
        else $error("write while disabled changed the state");

    // Change flags are never raised by a read.
    a_read_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_exec && is_read |-> !o_rsp.display_changed && !o_rsp.intensity_changed)
        else $error("read raised a change flag");

endmodule

// ----- design/alpha_display_controller.sv -----
// Sixteen-digit alphanumeric display controller, top level.
// A request is taken into the request register, then executed into the response register,
// which offers its response; one request per cycle sustained while the output does not stall.
// The request register advances whenever the response register is empty or taken.
// Reset (i_rst_n low, synchronous) empties both stages, fills the digits with blanks,
// sets cursor 15, duty 0, sixteen digits in use, and leaves the controller disabled.
module alpha_display_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  adc_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output adc_pkg::t_rsp o_out_rsp
);

    logic          r_req_valid;
    adc_pkg::t_req r_req;
    logic          r_out_valid;
    adc_pkg::t_rsp r_out;
    adc_pkg::t_rsp core_rsp;
    logic          advance;
    logic          exec;
    logic          in_take;

    // The request stage moves on when the response slot is free or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign exec       = r_req_valid && advance;
    assign o_in_stall = r_req_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    adc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (exec),
        .i_req   (r_req),
        .o_rsp   (core_rsp)
    );

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (in_take) begin
            r_req_valid <= 1'b1;
        end else if (exec) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= i_in_req;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= core_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the alphanumeric display controller: directed, character-table and
// random requests, checked against a shadow copy of the digit RAM and control state.
// Depends on adc_pkg and alpha_display_controller.
module tb;

    // Stored character to standardized code.
    localparam logic [5:0] CHAR_TO_STD [64] = '{
         0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15,
        16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 32, 28, 32, 32, 31,
        32, 32, 34, 35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45, 46, 47,
        48, 49, 50, 51, 52, 53, 54, 55, 56, 57, 57, 58, 59, 60, 61, 62
    };

    // Standardized code to segment pattern.
    localparam logic [15:0] STD_TO_SEG [64] = '{
        20607, 17615, 5439, 243, 4415, 16627, 16579, 1275,
        17612, 4403, 124, 19136, 240, 33484, 35020, 255,
        17607, 2303, 19655, 17595, 4355, 252, 8896, 10444,
        43520, 37376, 8755, 225, 34816, 30, 10240, 48,
        0, 33057, 384, 21820, 4539, 30617, 51577, 512,
        2560, 40960, 65280, 21760, 0, 17408, 0, 8704,
        8959, 4352, 17527, 17471, 17548, 17595, 17659, 15,
        17663, 17599, 33, 8193, 17456, 17456, 786, 5127
    };

    // Standardized code to ASCII.
    localparam logic [6:0] STD_TO_ASCII [64] = '{
        7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
        7'h48, 7'h49, 7'h4a, 7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h4f,
        7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h5a, 7'h3c, 7'h2f, 7'h3e, 7'h5e, 7'h5f,
        7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27,
        7'h28, 7'h29, 7'h2a, 7'h2b, 7'h2c, 7'h2d, 7'h2e, 7'h2f,
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h3d, 7'h20, 7'h3d, 7'h20, 7'h21, 7'h3f
    };

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    adc_pkg::t_req in_req;
    logic out_valid;
    logic out_stall;
    adc_pkg::t_rsp out_rsp;

    alpha_display_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the controller state.
    logic [5:0] shadow_char [adc_pkg::DIGITS];
    logic [7:0] shadow_punct [adc_pkg::DIGITS];
    logic [3:0] shadow_cursor;
    logic [4:0] shadow_duty;
    logic [4:0] shadow_count;
    logic       shadow_enabled;

    // Responses predicted for accepted requests, oldest first.
    adc_pkg::t_rsp expected_rsp_q [$];

    int  error_count = 0;
    int  requests_sent = 0;
    int  reads_sent = 0;
    int  responses_checked = 0;
    bit  idle_on = 1'b1;
    int  holdoff_cycles = 0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void clear_shadow();
        for (int i = 0; i < adc_pkg::DIGITS; i++) begin
            shadow_char[i] = adc_pkg::CH_BLANK;
            shadow_punct[i] = 8'h00;
        end
        shadow_cursor = adc_pkg::CURSOR_RESET;
        shadow_duty = 5'd0;
        shadow_count = adc_pkg::COUNT_RESET;
    endfunction

    // Apply one request to the shadow state and return the response it should produce.
    function automatic adc_pkg::t_rsp predict_display(input adc_pkg::t_req r);
        adc_pkg::t_rsp rsp;
        logic [5:0]    ch;
        logic [5:0]    code;
        rsp = '0;
        ch = r.data_byte[5:0];
        case (r.command)
            adc_pkg::CMD_WRITE: begin
                if (shadow_enabled) begin
                    case (r.data_byte[7:5])
                        adc_pkg::TOP_DUTY: begin
                            if (r.data_byte[4:0] != shadow_duty) begin
                                shadow_duty = r.data_byte[4:0];
                                rsp.intensity_changed = 1'b1;
                            end
                        end
                        adc_pkg::TOP_CURSOR: shadow_cursor = r.data_byte[3:0];
                        adc_pkg::TOP_COUNT: begin
                            shadow_count = (r.data_byte[4:0] == 5'd0) ?
                                           adc_pkg::COUNT_RESET : r.data_byte[4:0];
                        end
                        adc_pkg::TOP_TEST: ;
                        default: begin
                            // Punctuation lands on the current digit; other characters but null advance.
                            if (ch == adc_pkg::CH_DOT || ch == adc_pkg::CH_COMMA) begin
                                if (shadow_punct[shadow_cursor] == 8'h00)
                                    rsp.display_changed = 1'b1;
                                shadow_punct[shadow_cursor] |= {2'b00, ch};
                            end else if (ch != adc_pkg::CH_NULL) begin
                                shadow_cursor = shadow_cursor + 4'd1;
                                if (shadow_char[shadow_cursor] != ch)
                                    rsp.display_changed = 1'b1;
                                shadow_char[shadow_cursor] = ch;
                                shadow_punct[shadow_cursor] = 8'h00;
                            end
                        end
                    endcase
                end
            end
            adc_pkg::CMD_READ: begin
                code = CHAR_TO_STD[shadow_char[r.digit_index]];
                rsp.segment_pattern = STD_TO_SEG[code];
                rsp.ascii_code = STD_TO_ASCII[code];
                rsp.punct_mark = shadow_punct[r.digit_index];
            end
            adc_pkg::CMD_ENABLE: begin
                if (r.data_byte[0]) begin
                    shadow_enabled = 1'b1;
                end else begin
                    shadow_enabled = 1'b0;
                    clear_shadow();
                    rsp.display_changed = 1'b1;
                    rsp.intensity_changed = 1'b1;
                end
            end
            default: ;
        endcase
        rsp.intensity_now = shadow_duty;
        rsp.digit_count_now = shadow_count;
        rsp.cursor_now = shadow_cursor;
        rsp.enabled_now = shadow_enabled;
        return rsp;
    endfunction

    // Offer one request after a random gap when idling is on and hold it until it is taken.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] data,
                                input logic [3:0] idx);
        adc_pkg::t_req r;
        int            gap;
        r.command = cmd;
        r.data_byte = data;
        r.digit_index = idx;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_req = r;
        do @(posedge clk); while (in_stall === 1'b1);
        expected_rsp_q.push_back(predict_display(r));
        requests_sent++;
        if (cmd == adc_pkg::CMD_READ)
            reads_sent++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Compare every taken response with the oldest prediction.
    always @(posedge clk) begin : check_responses
        adc_pkg::t_rsp want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (expected_rsp_q.size() == 0) begin
                report_error("response with no request outstanding");
            end else begin
                want = expected_rsp_q.pop_front();
                responses_checked++;
                check_field("segment_pattern", 16'(out_rsp.segment_pattern),
                            16'(want.segment_pattern));
                check_field("ascii_code", 16'(out_rsp.ascii_code), 16'(want.ascii_code));
                check_field("punct_mark", 16'(out_rsp.punct_mark), 16'(want.punct_mark));
                check_field("display_changed", 16'(out_rsp.display_changed),
                            16'(want.display_changed));
                check_field("intensity_changed", 16'(out_rsp.intensity_changed),
                            16'(want.intensity_changed));
                check_field("intensity_now", 16'(out_rsp.intensity_now),
                            16'(want.intensity_now));
                check_field("digit_count_now", 16'(out_rsp.digit_count_now),
                            16'(want.digit_count_now));
                check_field("cursor_now", 16'(out_rsp.cursor_now), 16'(want.cursor_now));
                check_field("enabled_now", 16'(out_rsp.enabled_now), 16'(want.enabled_now));
            end
        end
    end

    // Response side: random stalls per response while idling is on, plus a long hold-off on request.
    initial begin
        int w;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (holdoff_cycles > 0) begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (holdoff_cycles) @(negedge clk);
                holdoff_cycles = 0;
            end
            w = idle_on ? $urandom_range(0, 3) : 0;
            repeat (w) begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Field extremes, every command, and the corner cases of byte decoding.
    task automatic test_directed_cases();
        send_request(adc_pkg::CMD_READ, 8'h00, 4'd0);
        send_request(adc_pkg::CMD_WRITE, 8'h41, 4'd15);
        send_request(adc_pkg::CMD_NONE, 8'hFF, 4'd15);
        send_request(adc_pkg::CMD_ENABLE, 8'h01, 4'd0);
        send_request(adc_pkg::CMD_ENABLE, 8'hFF, 4'd0);
        // A blank written over a blank leaves the display unchanged.
        send_request(adc_pkg::CMD_WRITE, {2'b00, adc_pkg::CH_BLANK}, 4'd0);
        send_request(adc_pkg::CMD_WRITE, 8'h7F, 4'd5);
        send_request(adc_pkg::CMD_WRITE, {2'b00, adc_pkg::CH_DOT}, 4'd9);
        send_request(adc_pkg::CMD_WRITE, {2'b01, adc_pkg::CH_COMMA}, 4'd2);
        send_request(adc_pkg::CMD_WRITE, {2'b00, adc_pkg::CH_NULL}, 4'd3);
        send_request(adc_pkg::CMD_WRITE, {2'b01, adc_pkg::CH_NULL}, 4'd4);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_DUTY, 5'h1F}, 4'd6);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_DUTY, 5'h1F}, 4'd7);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_DUTY, 5'h00}, 4'd8);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_COUNT, 5'h00}, 4'd10);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_COUNT, 5'h1F}, 4'd11);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_COUNT, 5'h01}, 4'd12);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_TEST, 5'h1F}, 4'd13);
        send_request(adc_pkg::CMD_READ, 8'hFF, 4'd1);
        // The cursor wraps from the last digit to the first.
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_CURSOR, 5'h1F}, 4'd14);
        send_request(adc_pkg::CMD_WRITE, 8'h01, 4'd0);
        send_request(adc_pkg::CMD_WRITE, {adc_pkg::TOP_CURSOR, 5'h00}, 4'd15);
        send_request(adc_pkg::CMD_ENABLE, 8'hFE, 4'd0);
        send_request(adc_pkg::CMD_ENABLE, 8'h00, 4'd0);
        send_request(adc_pkg::CMD_READ, 8'h00, 4'd1);
    endtask

    // Write every character but null, dot and comma and read it back, then stack punctuation on one digit.
    task automatic test_character_table();
        logic [5:0] c;
        send_request(adc_pkg::CMD_ENABLE, 8'h01, 4'd0);
        for (int k = 1; k < 64; k++) begin
            c = 6'(k);
            if (c == adc_pkg::CH_DOT || c == adc_pkg::CH_COMMA)
                continue;
            send_request(adc_pkg::CMD_WRITE, {1'b0, k[0], c}, 4'($urandom));
            send_request(adc_pkg::CMD_READ, 8'($urandom), shadow_cursor);
        end
        send_request(adc_pkg::CMD_WRITE, 8'h45, 4'd0);
        send_request(adc_pkg::CMD_WRITE, {2'b00, adc_pkg::CH_COMMA}, 4'd0);
        send_request(adc_pkg::CMD_READ, 8'h00, shadow_cursor);
        send_request(adc_pkg::CMD_WRITE, {2'b00, adc_pkg::CH_DOT}, 4'd0);
        send_request(adc_pkg::CMD_READ, 8'h00, shadow_cursor);
    endtask

    // The response side holds off long enough that the block fills and stalls input.
    task automatic test_output_holdoff();
        idle_on = 1'b0;
        send_request(adc_pkg::CMD_ENABLE, 8'h01, 4'd0);
        holdoff_cycles = 40;
        for (int n = 0; n < 24; n++)
            send_request(n[0] ? adc_pkg::CMD_READ : adc_pkg::CMD_WRITE, 8'(8'h41 + n),
                         n[3:0]);
        idle_on = 1'b1;
    endtask

    // Mostly enabled traffic: characters, punctuation, controls and reads,
    // with rare disables and the unused command mixed in.
    task automatic test_random_traffic(input int count);
        int         pick;
        logic [7:0] b;
        logic [3:0] idx;
        for (int n = 0; n < count; n++) begin
            // Every third stretch runs with no idling on either side.
            idle_on = ((n / 150) % 3) != 2;
            pick = $urandom_range(0, 99);
            b = 8'($urandom);
            idx = 4'($urandom);
            if (!shadow_enabled && pick < 50) begin
                send_request(adc_pkg::CMD_ENABLE, b | 8'h01, idx);
            end else if (pick < 1) begin
                send_request(adc_pkg::CMD_ENABLE, b, idx);
            end else if (pick < 3) begin
                send_request(adc_pkg::CMD_NONE, b, idx);
            end else if (pick < 33) begin
                send_request(adc_pkg::CMD_READ, b, idx);
            end else if (pick < 48) begin
                case ($urandom_range(0, 3))
                    0: b[7:5] = adc_pkg::TOP_DUTY;
                    1: b[7:5] = adc_pkg::TOP_CURSOR;
                    2: b[7:5] = adc_pkg::TOP_COUNT;
                    default: b[7:5] = adc_pkg::TOP_TEST;
                endcase
                send_request(adc_pkg::CMD_WRITE, b, idx);
            end else if (pick < 56) begin
                b[5:0] = $urandom_range(0, 1) ? adc_pkg::CH_DOT : adc_pkg::CH_COMMA;
                b[7] = 1'b0;
                send_request(adc_pkg::CMD_WRITE, b, idx);
            end else begin
                b[7] = 1'b0;
                send_request(adc_pkg::CMD_WRITE, b, idx);
            end
        end
    endtask

    // Run limit.
    initial begin
        #200000;
        $display("status: fail");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        shadow_enabled = 1'b0;
        clear_shadow();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_character_table();
        test_output_holdoff();
        test_random_traffic(1200);

        @(negedge clk);
        in_valid = 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests (%0d digit reads); checked %0d responses.",
                 requests_sent, reads_sent, responses_checked);
        $display("Covered decoding corners, all characters, output hold-off; errors: %0d.",
                 error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/adc_pkg.sv
design/adc_decode.sv
design/adc_core.sv
design/alpha_display_controller.sv
bench/tb.sv
